// ----- design/ohlc_pkg.sv -----
package ohlc_pkg;

    localparam int TIME_W   = 48;
    localparam int PRICE_W  = 32;
    localparam int VOL_W    = 32;
    localparam int CVOL_W   = 48;
    localparam int TF_W     = 32;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int STEP_W   = 6;

    localparam logic [TF_W-1:0]   TIMEFRAME_RESET = 32'd60000;
    localparam logic [STEP_W-1:0] LAST_STEP       = 6'(TIME_W - 1);
    localparam logic [CVOL_W-1:0] CVOL_MAX        = '1;

    // register index = word address bit
    localparam logic REG_PRICE_MODE = 1'b0;
    localparam logic REG_TIMEFRAME  = 1'b1;

    typedef enum logic [1:0] {
        MODE_MID   = 2'd0,
        MODE_BID   = 2'd1,
        MODE_OFFER = 2'd2,
        MODE_NONE  = 2'd3
    } t_price_mode;

    typedef enum logic [1:0] {
        STATUS_DROPPED = 2'd0,
        STATUS_UPDATED = 2'd1,
        STATUS_OPENED  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]  tick_time;
        logic [PRICE_W-1:0] bid_price;
        logic [PRICE_W-1:0] offer_price;
        logic [VOL_W-1:0]   tick_volume;
    } t_tick_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [TIME_W-1:0]  candle_start;
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
        logic [CVOL_W-1:0]  candle_volume;
    } t_candle_out;

    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  dividend;
        logic [TF_W-1:0]    divisor;
    } t_rem_req;

    typedef struct packed {
        logic               done;
        logic [TF_W-1:0]    rem;
    } t_rem_rsp;

endpackage

// ----- design/ohlc_cfg_regs.sv -----
module ohlc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ohlc_pkg::CFG_AW-1:0] paddr,
    input  logic [ohlc_pkg::CFG_DW-1:0] pwdata,
    output logic [ohlc_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output ohlc_pkg::t_price_mode       o_price_mode,
    output logic [ohlc_pkg::TF_W-1:0]   o_timeframe
);
    import ohlc_pkg::*;

    t_price_mode     r_price_mode;
    logic [TF_W-1:0] r_timeframe;
    logic            wr_en;

    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_price_mode <= MODE_MID;
            r_timeframe  <= TIMEFRAME_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_PRICE_MODE: r_price_mode <= t_price_mode'(pwdata[1:0]);
                REG_TIMEFRAME:  r_timeframe  <= pwdata[TF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PRICE_MODE: prdata = {30'd0, r_price_mode};
            REG_TIMEFRAME:  prdata = r_timeframe;
            default:        prdata = '0;
        endcase
    end

    assign o_price_mode = r_price_mode;
    assign o_timeframe  = r_timeframe;

endmodule

// ----- design/ohlc_rem_unit.sv -----
module ohlc_rem_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ohlc_pkg::t_rem_req i_req,
    output ohlc_pkg::t_rem_rsp o_rsp
);
    import ohlc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_count;
    logic [TIME_W-1:0] r_dvd;
    logic [TF_W-1:0]   r_dvs;
    logic [TF_W-1:0]   r_rem;
    logic [TF_W:0]     shifted;
    logic [TF_W+1:0]   diff;
    logic [TF_W-1:0]   n_rem;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        shifted = {r_rem, r_dvd[TIME_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        n_rem   = diff[TF_W+1] ? shifted[TF_W-1:0] : diff[TF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            // zero timeframe acts as one
            r_dvs <= (i_req.divisor == '0) ? TF_W'(1) : i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- design/tick_to_ohlc_candle_builder_top.sv -----
// OHLC candle builder: each accepted tick transfer yields exactly one result transfer carrying
// the candle snapshot after that tick and a status (0 dropped as stale or no price source,
// 1 candle updated, 2 new candle opened). The candle start is the tick time minus (time mod
// timeframe), and that remainder comes from a bit-serial restoring divider that consumes one
// timestamp bit per cycle. A kept tick goes through launch, divider steps, finish and update;
// the update waits for a free output register. A dropped tick skips the divider and goes
// straight to the update. One tick is in flight at a time; the next tick is taken as soon as
// the previous result sits in the output register, even if the sink still stalls it.
// Configuration (price_mode at byte address 0, timeframe at 4) is to be written over the
// APB-style port only while no tick is in flight (not enforced); zero timeframe acts as one.
module tick_to_ohlc_candle_builder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // tick input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ohlc_pkg::t_tick_in          i_in_tick,
    // candle result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ohlc_pkg::t_candle_out       o_out_candle,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ohlc_pkg::CFG_AW-1:0] paddr,
    input  logic [ohlc_pkg::CFG_DW-1:0] pwdata,
    output logic [ohlc_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import ohlc_pkg::*;

    // configuration
    t_price_mode     cfg_mode;
    logic [TF_W-1:0] cfg_tf;
    logic [TF_W-1:0] tf_eff;

    // sequencer and divider handshake
    t_state   r_state, n_state;
    t_rem_req rem_req;
    t_rem_rsp rem_rsp;

    // latched tick
    logic [TIME_W-1:0]  r_time;
    logic [PRICE_W-1:0] r_price;
    logic [VOL_W-1:0]   r_vol;
    logic               r_drop;

    // candle state
    logic [TIME_W-1:0]  r_last_time;
    logic               r_have;
    logic [TIME_W-1:0]  r_start;
    logic [PRICE_W-1:0] r_open;
    logic [PRICE_W-1:0] r_high;
    logic [PRICE_W-1:0] r_low;
    logic [PRICE_W-1:0] r_close;
    logic [CVOL_W-1:0]  r_volume;

    // output register
    logic        r_out_valid;
    t_candle_out r_out;

    // combinational helpers
    logic               accept;
    logic               stale;
    logic [PRICE_W:0]   mid_sum;
    logic [PRICE_W-1:0] tick_price;
    logic               out_free;
    logic               commit;
    logic [TIME_W-1:0]  base;
    logic [TIME_W:0]    end_time;
    logic               open_new;
    logic [CVOL_W:0]    vol_sum;
    t_candle_out        n_out;

    ohlc_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_price_mode (cfg_mode),
        .o_timeframe  (cfg_tf)
    );

    ohlc_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    assign tf_eff = (cfg_tf == '0) ? TF_W'(1) : cfg_tf;

    // input side: take a tick only while nothing is in flight
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    // drop ticks that are not newer than the last kept one, or lack a price source
    assign stale = (i_in_tick.tick_time <= r_last_time) || (cfg_mode == MODE_NONE);

    always_comb begin
        mid_sum = {1'b0, i_in_tick.bid_price} + {1'b0, i_in_tick.offer_price};
        case (cfg_mode)
            MODE_MID:   tick_price = mid_sum[PRICE_W:1];
            MODE_BID:   tick_price = i_in_tick.bid_price;
            MODE_OFFER: tick_price = i_in_tick.offer_price;
            default:    tick_price = '0;
        endcase
    end

    // launch the remainder only for kept ticks
    assign rem_req.start    = accept && !stale;
    assign rem_req.dividend = i_in_tick.tick_time;
    assign rem_req.divisor  = cfg_tf;

    // output register frees up when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = (r_state == ST_UPDATE) && out_free;

    // candle update for a kept tick
    always_comb begin
        base     = r_time - {{(TIME_W-TF_W){1'b0}}, rem_rsp.rem};
        end_time = {1'b0, r_start} + {{(TIME_W-TF_W+1){1'b0}}, tf_eff};
        open_new = !r_have || (end_time <= {1'b0, base});
        vol_sum  = (open_new ? {(CVOL_W+1){1'b0}} : {1'b0, r_volume})
                 + {{(CVOL_W-VOL_W+1){1'b0}}, r_vol};

        if (r_drop) begin
            n_out.status        = STATUS_DROPPED;
            n_out.candle_start  = r_start;
            n_out.open_price    = r_open;
            n_out.high_price    = r_high;
            n_out.low_price     = r_low;
            n_out.close_price   = r_close;
            n_out.candle_volume = r_volume;
        end else begin
            n_out.status        = open_new ? STATUS_OPENED : STATUS_UPDATED;
            n_out.candle_start  = open_new ? base : r_start;
            n_out.open_price    = open_new ? r_price : r_open;
            n_out.high_price    = (open_new || r_price > r_high) ? r_price : r_high;
            n_out.low_price     = (open_new || r_price < r_low) ? r_price : r_low;
            n_out.close_price   = r_price;
            // saturate at the top of the 48-bit range
            n_out.candle_volume = vol_sum[CVOL_W] ? CVOL_MAX : vol_sum[CVOL_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = stale ? ST_UPDATE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_rsp.done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // hold the accepted tick for the update
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time  <= i_in_tick.tick_time;
            r_price <= tick_price;
            r_vol   <= i_in_tick.tick_volume;
            r_drop  <= stale;
        end
    end

    // candle state: advance only on a kept tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_have      <= 1'b0;
            r_start     <= '0;
            r_open      <= '0;
            r_high      <= '0;
            r_low       <= '0;
            r_close     <= '0;
            r_volume    <= '0;
        end else if (commit && !r_drop) begin
            r_last_time <= r_time;
            r_have      <= 1'b1;
            r_start     <= n_out.candle_start;
            r_open      <= n_out.open_price;
            r_high      <= n_out.high_price;
            r_low       <= n_out.low_price;
            r_close     <= n_out.close_price;
            r_volume    <= n_out.candle_volume;
        end
    end

    // result register: load on commit, drain on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_candle = r_out;

endmodule
